@@ src/lamb_pkg.sv @@
`default_nettype none
package lamb_pkg;

  localparam int FRAC_BITS = 16;

  // Wide signed width used for exact sums before rounding.
  localparam int RW = 68;
  // Width of the partial products of the reciprocal square root search.
  localparam int PW = 4 * FRAC_BITS + 5;
  // Width in which the shifted terms are formed before the overflow check.
  localparam int EW = PW + 124;
  // One pipeline stage per result bit of the reciprocal square root.
  localparam int NS = 31;

  localparam int IN_W = 288;
  localparam int OUT_W = 136;
  localparam int USER_W = 2;
  localparam int ROW_CNT_W = 3;

  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [RW-1:0] HALF_Q = RW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [PW+1:0] RS_LIMIT = (PW + 2)'(1) << (4 * FRAC_BITS + 2);

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0] vec3_t;
  typedef logic signed [63:0] prod_t;

  // Values that travel alongside an item through the pipeline.
  typedef struct packed {
    vec3_t eye;
    vec3_t up;
    vec3_t ax;
    vec3_t az;
    logic  deg;
  } carry_t;

  // Round half up to FRAC_BITS fraction bits and saturate to 32 bits.
  function automatic word_t rnd_sat(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] t;
    logic [RW-32:0] hi;
    t = (v + HALF_Q) >>> FRAC_BITS;
    hi = t[RW-1:31];
    if (hi == '0 || hi == '1) begin
      rnd_sat = t[31:0];
    end else if (t[RW-1]) begin
      rnd_sat = 32'sh8000_0000;
    end else begin
      rnd_sat = 32'sh7fff_ffff;
    end
  endfunction

  // Saturating a - b.
  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [32:0] d;
    d = 33'($signed(a)) - 33'($signed(b));
    if (d[32] != d[31]) begin
      sat_sub = d[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sat_sub = d[31:0];
    end
  endfunction

endpackage
`default_nettype wire

@@ src/look_at_matrix_builder.sv @@
// Look-at view matrix builder.
// The slave channel takes one transaction per camera: tdata carries eye x/y/z,
// target x/y/z and up hint x/y/z, each signed Q16.16, from the lowest bits up.
// For every input transaction the master channel sends eight transactions:
// the four rows of the forward matrix (columns forward, up and side axes plus
// the eye point) followed by the four rows of its inverse. m_tlast marks the
// eighth row; m_tuser bit 0 selects the inverse matrix and bit 1 flags a zero
// length axis seen while normalizing.
// The core is a fully pipelined chain: difference, three normalizers (each
// with a 31-stage reciprocal square root search), two cross products and the
// inverse translation dot products. Without stalls an input is loaded into
// the row buffer once it leaves the last stage, and its first row can be
// taken at the following clock edge.
// The pipeline takes an input every cycle unless frozen, but the row buffer
// sends eight rows per input, so it loads one input per eight rows sent.
// When the receiver stalls, the row buffer holds its row and the whole
// pipeline freezes once its last stage is full; nothing is dropped.
// Synchronous reset clears all valid bits; no transaction is in flight after.
`default_nettype none
module look_at_matrix_builder (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z,
  // up_hint_x, up_hint_y, up_hint_z (32 bits each)
  input  wire logic [lamb_pkg::IN_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // row_index (2), col_0, col_1, col_2, col_3 (32 each), 6 zero bits
  output logic [lamb_pkg::OUT_W-1:0]      m_tdata,
  // matrix_select, degenerate
  output logic [lamb_pkg::USER_W-1:0]     m_tuser,
  output logic                            m_tlast
);
  import lamb_pkg::*;

  logic   adv;

  // Input stage: eye, up hint and saturated target minus eye.
  logic   s0_valid;
  vec3_t  s0_d;
  carry_t s0_c;

  logic   n1_valid, x1_valid, n2_valid, x2_valid, n3_valid;
  vec3_t  n1_v, x1_v, n2_v, x2_v, n3_v;
  carry_t n1_c, x1_c, n2_c, x2_c, n3_c;
  carry_t cx1, cx2;

  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s0_c.eye[i] <= s_tdata[32*i +: 32];
        s0_c.up[i]  <= s_tdata[32*(6+i) +: 32];
        s0_d[i]     <= sat_sub(s_tdata[32*(3+i) +: 32], s_tdata[32*i +: 32]);
      end
      s0_c.ax  <= '0;
      s0_c.az  <= '0;
      s0_c.deg <= 1'b0;
    end
  end

  // Forward axis.
  lamb_norm u_norm_fwd (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(s0_valid), .vin(s0_d), .cin(s0_c),
    .out_valid(n1_valid), .vout(n1_v), .cout(n1_c)
  );

  always_comb begin
    cx1 = n1_c;
    cx1.ax = n1_v;
  end

  // Side axis, unnormalized: forward cross up hint.
  lamb_cross u_cross_side (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(n1_valid), .a(n1_v), .b(n1_c.up), .cin(cx1),
    .out_valid(x1_valid), .vout(x1_v), .cout(x1_c)
  );

  lamb_norm u_norm_side (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(x1_valid), .vin(x1_v), .cin(x1_c),
    .out_valid(n2_valid), .vout(n2_v), .cout(n2_c)
  );

  always_comb begin
    cx2 = n2_c;
    cx2.az = n2_v;
  end

  // Up axis, unnormalized: side cross forward.
  lamb_cross u_cross_up (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(n2_valid), .a(n2_v), .b(n2_c.ax), .cin(cx2),
    .out_valid(x2_valid), .vout(x2_v), .cout(x2_c)
  );

  lamb_norm u_norm_up (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(x2_valid), .vin(x2_v), .cin(x2_c),
    .out_valid(n3_valid), .vout(n3_v), .cout(n3_c)
  );

  // Inverse translation and the row buffer; it also drives the pipeline enable.
  lamb_out u_out (
    .clk(clk), .rst(rst),
    .in_valid(n3_valid), .ay(n3_v), .cin(n3_c),
    .adv(adv),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

endmodule
`default_nettype wire

@@ src/lamb_norm.sv @@
`default_nettype none
module lamb_norm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire lamb_pkg::vec3_t vin,
  input  wire lamb_pkg::carry_t cin,
  output logic                 out_valid,
  output lamb_pkg::vec3_t      vout,
  output lamb_pkg::carry_t     cout
);
  import lamb_pkg::*;

  // Squares stage.
  logic   sq_valid;
  prod_t  sq [3];
  vec3_t  sq_v;
  carry_t sq_c;

  // Search stages; entry 0 holds the squared length, entry k the first k bits.
  logic [NS:0]     vld_a;
  logic [63:0]     s_a [0:NS];
  logic [PW-1:0]   p_a [0:NS];
  logic [PW-1:0]   q_a [0:NS];
  logic [30:0]     r_a [0:NS];
  vec3_t           v_a [0:NS];
  carry_t          c_a [0:NS];

  logic [PW-1:0]   p_nx [0:NS-1];
  logic [PW-1:0]   q_nx [0:NS-1];
  logic [30:0]     r_nx [0:NS-1];

  // Scaling stage.
  logic   m_valid;
  prod_t  m_p [3];
  carry_t m_c;

  logic [30:0] r_fin;
  logic        s_zero;
  carry_t      c_fin;

  // Each stage decides one bit of r, keeping P = r*r*s and Q = r*s exact.
  always_comb begin
    logic [EW-1:0] t0, t1, t2, t3;
    logic [PW+1:0] pc, qc, fv;
    logic          ov, acc;
    int            b;
    for (int k = 0; k < NS; k++) begin
      b = NS - 1 - k;
      t0 = EW'(s_a[k]);
      t1 = t0 << (2 * b);
      t2 = EW'(q_a[k]) << (b + 1);
      t3 = t0 << b;
      ov = (|t1[EW-1:PW]) || (|t2[EW-1:PW]);
      pc = (PW + 2)'(p_a[k]) + (PW + 2)'(t1[PW-1:0]) + (PW + 2)'(t2[PW-1:0]);
      qc = (PW + 2)'(q_a[k]) + (PW + 2)'(t3[PW-1:0]);
      fv = (pc << 2) - (qc << 2) + (PW + 2)'(t0[PW-1:0]);
      acc = !ov && (pc <= RS_LIMIT) && (fv <= RS_LIMIT);
      p_nx[k] = acc ? pc[PW-1:0] : p_a[k];
      q_nx[k] = acc ? qc[PW-1:0] : q_a[k];
      r_nx[k] = acc ? (r_a[k] | (31'(1) << b)) : r_a[k];
    end
  end

  assign s_zero = (s_a[NS] == '0);
  assign r_fin  = s_zero ? '0 : r_a[NS];

  always_comb begin
    c_fin     = c_a[NS];
    c_fin.deg = c_a[NS].deg | s_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      vld_a     <= '0;
      m_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sq_valid  <= in_valid;
      vld_a     <= {vld_a[NS-1:0], sq_valid};
      m_valid   <= vld_a[NS];
      out_valid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= $signed(vin[i]) * $signed(vin[i]);
      end
      sq_v <= vin;
      sq_c <= cin;

      s_a[0] <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
      p_a[0] <= '0;
      q_a[0] <= '0;
      r_a[0] <= '0;
      v_a[0] <= sq_v;
      c_a[0] <= sq_c;
      for (int k = 0; k < NS; k++) begin
        s_a[k+1] <= s_a[k];
        p_a[k+1] <= p_nx[k];
        q_a[k+1] <= q_nx[k];
        r_a[k+1] <= r_nx[k];
        v_a[k+1] <= v_a[k];
        c_a[k+1] <= c_a[k];
      end

      for (int i = 0; i < 3; i++) begin
        m_p[i] <= $signed(v_a[NS][i]) * $signed({1'b0, r_fin});
      end
      m_c <= c_fin;

      for (int i = 0; i < 3; i++) begin
        vout[i] <= rnd_sat(RW'(m_p[i]));
      end
      cout <= m_c;
    end
  end

endmodule
`default_nettype wire

@@ src/lamb_cross.sv @@
`default_nettype none
module lamb_cross (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire lamb_pkg::vec3_t  a,
  input  wire lamb_pkg::vec3_t  b,
  input  wire lamb_pkg::carry_t cin,
  output logic                  out_valid,
  output lamb_pkg::vec3_t       vout,
  output lamb_pkg::carry_t      cout
);
  import lamb_pkg::*;

  logic   p_valid;
  prod_t  pp [3];
  prod_t  pn [3];
  carry_t p_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  // Component i is a[j]*b[k] - a[k]*b[j], rounded once.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pp[i] <= $signed(a[(i + 1) % 3]) * $signed(b[(i + 2) % 3]);
        pn[i] <= $signed(a[(i + 2) % 3]) * $signed(b[(i + 1) % 3]);
      end
      p_c <= cin;
      for (int i = 0; i < 3; i++) begin
        vout[i] <= rnd_sat(RW'(pp[i]) - RW'(pn[i]));
      end
      cout <= p_c;
    end
  end

endmodule
`default_nettype wire

@@ src/lamb_out.sv @@
`default_nettype none
module lamb_out (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire lamb_pkg::vec3_t             ay,
  input  wire lamb_pkg::carry_t            cin,
  output logic                             adv,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [lamb_pkg::OUT_W-1:0]       m_tdata,
  output logic [lamb_pkg::USER_W-1:0]      m_tuser,
  output logic                             m_tlast
);
  import lamb_pkg::*;

  localparam logic [1:0] ROW_LAST = 2'd3;
  localparam logic [ROW_CNT_W-1:0] CNT_LAST = ROW_CNT_W'(7);

  vec3_t axs [3];

  logic  d1_valid;
  prod_t d1_p [3][3];
  vec3_t d1_ax [3];
  vec3_t d1_eye;
  logic  d1_deg;

  logic  d2_valid;
  word_t d2_dot [3];
  vec3_t d2_ax [3];
  vec3_t d2_eye;
  logic  d2_deg;

  logic  full;
  logic [ROW_CNT_W-1:0] cnt;
  word_t b_dot [3];
  vec3_t b_ax [3];
  vec3_t b_eye;
  logic  b_deg;

  logic  load;
  logic [1:0] row;
  word_t c0, c1, c2, c3;

  always_comb begin
    axs[0] = cin.ax;
    axs[1] = ay;
    axs[2] = cin.az;
  end

  assign load = d2_valid && (!full || (m_tready && cnt == CNT_LAST));
  assign adv  = !d2_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_valid <= 1'b0;
      d2_valid <= 1'b0;
      full     <= 1'b0;
      cnt      <= '0;
    end else begin
      if (adv) begin
        d1_valid <= in_valid;
        d2_valid <= d1_valid;
      end
      if (load) begin
        full <= 1'b1;
        cnt  <= '0;
      end else if (full && m_tready) begin
        if (cnt == CNT_LAST) begin
          full <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          d1_p[r][i] <= $signed(cin.eye[i]) * $signed(axs[r][i]);
        end
        d1_ax[r] <= axs[r];
      end
      d1_eye <= cin.eye;
      d1_deg <= cin.deg;

      for (int r = 0; r < 3; r++) begin
        d2_dot[r] <= rnd_sat(-(RW'(d1_p[r][0]) + RW'(d1_p[r][1]) + RW'(d1_p[r][2])));
        d2_ax[r]  <= d1_ax[r];
      end
      d2_eye <= d1_eye;
      d2_deg <= d1_deg;
    end
    if (load) begin
      b_dot <= d2_dot;
      b_ax  <= d2_ax;
      b_eye <= d2_eye;
      b_deg <= d2_deg;
    end
  end

  // Rows 0..3 of the forward matrix, then rows 0..3 of the inverse.
  always_comb begin
    row = cnt[1:0];
    c0 = '0;
    c1 = '0;
    c2 = '0;
    c3 = ONE_Q;
    if (row != ROW_LAST) begin
      if (!cnt[2]) begin
        c0 = b_ax[0][row];
        c1 = b_ax[1][row];
        c2 = b_ax[2][row];
        c3 = b_eye[row];
      end else begin
        c0 = b_ax[row][0];
        c1 = b_ax[row][1];
        c2 = b_ax[row][2];
        c3 = b_dot[row];
      end
    end
    m_tdata  = {6'b0, c3, c2, c1, c0, row};
    m_tuser  = {b_deg, cnt[2]};
    m_tlast  = (cnt == CNT_LAST);
    m_tvalid = full;
  end

endmodule
`default_nettype wire
